// File: design/tgad_pkg.sv
// tgad_pkg: shared types and constants of the TGA true-color stream decoder.
// Result kinds, header byte offsets and the result record.
// No dependencies.
`timescale 1ns / 1ps

package tgad_pkg;

   typedef enum logic [1:0] {
      KIND_PIXEL = 2'd0,
      KIND_LAST  = 2'd1,
      KIND_FAIL  = 2'd2
   } kind_type;

   // header byte offsets
   localparam logic [4:0] HDR_ID_LEN    = 5'd0;
   localparam logic [4:0] HDR_CMAP_TYPE = 5'd1;
   localparam logic [4:0] HDR_IMG_TYPE  = 5'd2;
   localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
   localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
   localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
   localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
   localparam logic [4:0] HDR_DEPTH     = 5'd16;
   localparam logic [4:0] HDR_DESC      = 5'd17;

   localparam logic [7:0] IMG_TYPE_TRUECOLOR = 8'd2;
   localparam logic [7:0] DEPTH_24           = 8'd24;
   localparam logic [7:0] DEPTH_32           = 8'd32;
   localparam int         DESC_TOP_DOWN_BIT  = 5;
   localparam logic [7:0] ALPHA_OPAQUE       = 8'hFF;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      logic [7:0]  alpha;
      logic [15:0] column;
      logic [15:0] dest_row;
      logic [15:0] image_width;
      logic [15:0] image_height;
   } result_type;

endpackage

// File: design/tgad_if.sv
// tgad_if: valid/ready channel interfaces for file bytes and decoded results.
// No dependencies.
`timescale 1ns / 1ps

interface tgad_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_file;

   modport source (output valid, output data_byte, output end_of_file, input ready);
   modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface tgad_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  blue;
   logic [7:0]  green;
   logic [7:0]  red;
   logic [7:0]  alpha;
   logic [15:0] column;
   logic [15:0] dest_row;
   logic [15:0] image_width;
   logic [15:0] image_height;

   modport source (output valid, output kind, output blue, output green, output red,
                   output alpha, output column, output dest_row, output image_width,
                   output image_height, input ready);
   modport sink   (input valid, input kind, input blue, input green, input red,
                   input alpha, input column, input dest_row, input image_width,
                   input image_height, output ready);
endinterface

// File: design/tgad_core.sv
// tgad_core: header capture, ID skip and pixel assembly state machine.
// Produces at most one result per accepted byte. Depends on tgad_pkg.
`timescale 1ns / 1ps

module tgad_core
   import tgad_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_fire,
   input  logic [7:0]  data_byte,
   input  logic        end_of_file,
   output logic        res_valid,
   output result_type  res
);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_SKIP,
      PH_PIXELS,
      PH_DONE,
      PH_FAILED
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [4:0]  header_count_ff, header_count_in;
   logic [7:0]  id_skip_ff, id_skip_in;
   logic        type_ok_ff, type_ok_in;
   logic [15:0] hdr_width_ff, hdr_width_in;
   logic [15:0] hdr_height_ff, hdr_height_in;
   logic        four_byte_ff, four_byte_in;
   logic        top_down_ff, top_down_in;
   logic [1:0]  byte_in_pixel_ff, byte_in_pixel_in;
   logic [23:0] pixel_hold_ff, pixel_hold_in;
   logic [15:0] col_count_ff, col_count_in;
   logic [15:0] row_count_ff, row_count_in;

   logic [1:0]  last_byte;
   logic        col_end;
   logic        row_end;
   logic [15:0] flip_row;

   assign last_byte = four_byte_ff ? 2'd3 : 2'd2;
   assign col_end   = ({1'b0, col_count_ff} + 17'd1) >= {1'b0, hdr_width_ff};
   assign row_end   = ({1'b0, row_count_ff} + 17'd1) >= {1'b0, hdr_height_ff};
   assign flip_row  = hdr_height_ff - 16'd1 - row_count_ff;

   always_comb begin
      phase_in         = phase_ff;
      header_count_in  = header_count_ff;
      id_skip_in       = id_skip_ff;
      type_ok_in       = type_ok_ff;
      hdr_width_in     = hdr_width_ff;
      hdr_height_in    = hdr_height_ff;
      four_byte_in     = four_byte_ff;
      top_down_in      = top_down_ff;
      byte_in_pixel_in = byte_in_pixel_ff;
      pixel_hold_in    = pixel_hold_ff;
      col_count_in     = col_count_ff;
      row_count_in     = row_count_ff;
      res_valid        = 1'b0;
      res              = '0;
      res.kind         = KIND_PIXEL;

      if (in_fire) begin
         case (phase_ff)
            PH_HEADER: begin
               case (header_count_ff)
                  HDR_ID_LEN:    id_skip_in = data_byte;
                  HDR_CMAP_TYPE: type_ok_in = (data_byte == 8'd0);
                  HDR_IMG_TYPE: begin
                     if (data_byte != IMG_TYPE_TRUECOLOR) type_ok_in = 1'b0;
                  end
                  HDR_WIDTH_LO:  hdr_width_in = {8'h00, data_byte};
                  HDR_WIDTH_HI:  hdr_width_in = {data_byte, hdr_width_ff[7:0]};
                  HDR_HEIGHT_LO: hdr_height_in = {8'h00, data_byte};
                  HDR_HEIGHT_HI: hdr_height_in = {data_byte, hdr_height_ff[7:0]};
                  HDR_DEPTH: begin
                     if (data_byte == DEPTH_32) begin
                        four_byte_in = 1'b1;
                     end else if (data_byte == DEPTH_24) begin
                        four_byte_in = 1'b0;
                     end else begin
                        type_ok_in = 1'b0;
                     end
                  end
                  HDR_DESC:      top_down_in = data_byte[DESC_TOP_DOWN_BIT];
                  default: ;
               endcase
               header_count_in = header_count_ff + 5'd1;
               if (header_count_ff == HDR_DESC) begin
                  if (type_ok_in && (hdr_width_in != 16'd0) && (hdr_height_in != 16'd0)) begin
                     phase_in = (id_skip_in != 8'd0) ? PH_SKIP : PH_PIXELS;
                  end else begin
                     res_valid = 1'b1;
                     res.kind  = KIND_FAIL;
                     phase_in  = PH_FAILED;
                  end
               end
            end
            PH_SKIP: begin
               id_skip_in = id_skip_ff - 8'd1;
               if (id_skip_in == 8'd0) phase_in = PH_PIXELS;
            end
            PH_PIXELS: begin
               if (byte_in_pixel_ff < last_byte) begin
                  case (byte_in_pixel_ff)
                     2'd0:    pixel_hold_in[7:0]   = data_byte;
                     2'd1:    pixel_hold_in[15:8]  = data_byte;
                     default: pixel_hold_in[23:16] = data_byte;
                  endcase
                  byte_in_pixel_in = byte_in_pixel_ff + 2'd1;
               end else begin
                  res_valid    = 1'b1;
                  res.kind     = (col_end && row_end) ? KIND_LAST : KIND_PIXEL;
                  res.blue     = pixel_hold_ff[7:0];
                  res.green    = pixel_hold_ff[15:8];
                  res.red      = four_byte_ff ? pixel_hold_ff[23:16] : data_byte;
                  res.alpha    = four_byte_ff ? data_byte : ALPHA_OPAQUE;
                  res.column   = col_count_ff;
                  res.dest_row = top_down_ff ? row_count_ff : flip_row;
                  byte_in_pixel_in = 2'd0;
                  pixel_hold_in    = '0;
                  if (col_end && row_end) begin
                     phase_in = PH_DONE;
                  end else if (col_end) begin
                     col_count_in = 16'd0;
                     row_count_in = row_count_ff + 16'd1;
                  end else begin
                     col_count_in = col_count_ff + 16'd1;
                  end
               end
            end
            default: ;
         endcase

         res.image_width  = hdr_width_in;
         res.image_height = hdr_height_in;

         if (end_of_file) begin
            if (phase_in == PH_HEADER || phase_in == PH_SKIP || phase_in == PH_PIXELS) begin
               res_valid    = 1'b1;
               res.kind     = KIND_FAIL;
               res.blue     = 8'd0;
               res.green    = 8'd0;
               res.red      = 8'd0;
               res.alpha    = 8'd0;
               res.column   = 16'd0;
               res.dest_row = 16'd0;
            end
            phase_in         = PH_HEADER;
            header_count_in  = '0;
            id_skip_in       = '0;
            type_ok_in       = 1'b0;
            hdr_width_in     = '0;
            hdr_height_in    = '0;
            four_byte_in     = 1'b0;
            top_down_in      = 1'b0;
            byte_in_pixel_in = '0;
            pixel_hold_in    = '0;
            col_count_in     = '0;
            row_count_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HEADER;
         header_count_ff  <= '0;
         id_skip_ff       <= '0;
         type_ok_ff       <= 1'b0;
         hdr_width_ff     <= '0;
         hdr_height_ff    <= '0;
         four_byte_ff     <= 1'b0;
         top_down_ff      <= 1'b0;
         byte_in_pixel_ff <= '0;
         pixel_hold_ff    <= '0;
         col_count_ff     <= '0;
         row_count_ff     <= '0;
      end else begin
         phase_ff         <= phase_in;
         header_count_ff  <= header_count_in;
         id_skip_ff       <= id_skip_in;
         type_ok_ff       <= type_ok_in;
         hdr_width_ff     <= hdr_width_in;
         hdr_height_ff    <= hdr_height_in;
         four_byte_ff     <= four_byte_in;
         top_down_ff      <= top_down_in;
         byte_in_pixel_ff <= byte_in_pixel_in;
         pixel_hold_ff    <= pixel_hold_in;
         col_count_ff     <= col_count_in;
         row_count_ff     <= row_count_in;
      end
   end

endmodule

// File: design/tgad_out.sv
// tgad_out: result register between the decoder core and the result channel.
// Frees itself in the cycle the receiver takes the result. Depends on tgad_pkg.
`timescale 1ns / 1ps

module tgad_out
   import tgad_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   input  logic       take,
   output logic       free,
   output logic       valid,
   output result_type data
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign free  = !valid_ff || take;
   assign valid = valid_ff;
   assign data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (take) valid_in = 1'b0;
      if (load) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

// File: design/tga_truecolor_stream_decoder.sv
// tga_truecolor_stream_decoder: top level of the uncompressed true-color TGA decoder.
// Depends on tgad_pkg, tgad_if, tgad_core and tgad_out.
//
// Usage:
//   req_chan carries the file one byte per transfer, end_of_file set on the last byte.
//   rsp_chan carries decoded pixels with column, destination row and header size.
//   kind is pixel, final pixel (success) or failure; on failure the receiver drops
//   the pixels it already got for that file.
//   Latency: a result is on rsp_chan the cycle after the byte that completes it.
//   Throughput: one byte per cycle while req_chan.ready is high; each byte goes through
//   one pass of the core's state update into a single result register.
//   Header bytes but a failing last one, ID and non-final pixel bytes give no result without end_of_file.
//   Reset: decoder returns to the header phase and the result register empties.
//   Stall: a result waits in the result register; req_chan.ready drops only while
//   that register is full and rsp_chan.ready is low.
`timescale 1ns / 1ps

module tga_truecolor_stream_decoder
   import tgad_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tgad_req_if.sink    req_chan,
   tgad_rsp_if.source  rsp_chan
);

   logic       in_fire;
   logic       res_valid;
   result_type res;
   logic       out_free;
   logic       out_valid;
   result_type out_data;

   assign req_chan.ready = out_free;
   assign in_fire        = req_chan.valid && out_free;

   tgad_core u_core (
      .clock       (clock),
      .reset       (reset),
      .in_fire     (in_fire),
      .data_byte   (req_chan.data_byte),
      .end_of_file (req_chan.end_of_file),
      .res_valid   (res_valid),
      .res         (res)
   );

   tgad_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (in_fire && res_valid),
      .load_data (res),
      .take      (rsp_chan.ready),
      .free      (out_free),
      .valid     (out_valid),
      .data      (out_data)
   );

   assign rsp_chan.valid        = out_valid;
   assign rsp_chan.kind         = out_data.kind;
   assign rsp_chan.blue         = out_data.blue;
   assign rsp_chan.green        = out_data.green;
   assign rsp_chan.red          = out_data.red;
   assign rsp_chan.alpha        = out_data.alpha;
   assign rsp_chan.column       = out_data.column;
   assign rsp_chan.dest_row     = out_data.dest_row;
   assign rsp_chan.image_width  = out_data.image_width;
   assign rsp_chan.image_height = out_data.image_height;

endmodule

// File: design/tgad_chk.sv
// tgad_chk: port-level checks of the TGA decoder, bound to the top level.
// Depends on tgad_pkg and tga_truecolor_stream_decoder.
`timescale 1ns / 1ps

module tgad_chk
   import tgad_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [7:0]  rsp_blue,
   input logic [7:0]  rsp_green,
   input logic [7:0]  rsp_red,
   input logic [7:0]  rsp_alpha,
   input logic [15:0] rsp_column,
   input logic [15:0] rsp_dest_row
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result without an input transfer");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while result register free");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_FAIL |-> rsp_blue == 8'd0 && rsp_green == 8'd0 &&
      rsp_red == 8'd0 && rsp_alpha == 8'd0 && rsp_column == 16'd0 &&
      rsp_dest_row == 16'd0)
      else $error("failure result carries pixel data");

endmodule

bind tga_truecolor_stream_decoder tgad_chk u_chk (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_kind     (rsp_chan.kind),
   .rsp_blue     (rsp_chan.blue),
   .rsp_green    (rsp_chan.green),
   .rsp_red      (rsp_chan.red),
   .rsp_alpha    (rsp_chan.alpha),
   .rsp_column   (rsp_chan.column),
   .rsp_dest_row (rsp_chan.dest_row)
);

// File: verif/tga_truecolor_stream_decoder_tb.sv
// tga_truecolor_stream_decoder_tb: self-checking bench for the TGA true-color byte decoder.
// Directed table of short files, then random files with bursty input and a stalling sink.
// Depends on tgad_pkg, tgad_if and the tga_truecolor_stream_decoder RTL.
`timescale 1ns / 1ps

module tga_truecolor_stream_decoder_tb;
   import tgad_pkg::*;

   localparam int          RANDOM_ITEMS = 1450;
   localparam int          CYCLE_LIMIT  = 500000;
   localparam int          DRAIN_CYCLES = 10;
   localparam int          MAX_REPORTS  = 50;
   localparam logic [4:0]  HEADER_BYTES = 5'd18;

   typedef enum logic [2:0] {
      ST_HEADER, ST_SKIP, ST_PIXELS, ST_DONE, ST_FAILED
   } decode_phase_type;

   typedef enum logic [1:0] {
      RX_FREE, RX_COIN, RX_MOSTLY, RX_EVERY_THIRD
   } rx_mode_type;

   typedef struct packed {
      logic [7:0] data;
      logic       eof;
      logic       pinned;
      result_type want;
   } dir_row_type;

   localparam result_type NO_PIN        = '0;
   localparam result_type WANT_EOF_FAIL =
      '{KIND_FAIL, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 16'd0, 16'd0, 16'd0};
   localparam result_type WANT_ONE_PIXEL =
      '{KIND_LAST, 8'h00, 8'h80, 8'hFF, ALPHA_OPAQUE, 16'd0, 16'd0, 16'd1, 16'd1};

   // end of file on the first byte, then a 1x1 24-bit bottom-up file with one ID byte
   // and a trailing byte after the final pixel
   localparam int DIR_ROWS = 24;
   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      '{8'hFF, 1'b1, 1'b1, WANT_EOF_FAIL},
      '{8'h01, 1'b0, 1'b0, NO_PIN},
      '{8'h00, 1'b0, 1'b0, NO_PIN},
      '{IMG_TYPE_TRUECOLOR, 1'b0, 1'b0, NO_PIN},
      '{8'h00, 1'b0, 1'b0, NO_PIN},
      '{8'h00, 1'b0, 1'b0, NO_PIN},
      '{8'h00, 1'b0, 1'b0, NO_PIN},
      '{8'h00, 1'b0, 1'b0, NO_PIN},
      '{8'h00, 1'b0, 1'b0, NO_PIN},
      '{8'h00, 1'b0, 1'b0, NO_PIN},
      '{8'h00, 1'b0, 1'b0, NO_PIN},
      '{8'h00, 1'b0, 1'b0, NO_PIN},
      '{8'h00, 1'b0, 1'b0, NO_PIN},
      '{8'h01, 1'b0, 1'b0, NO_PIN},
      '{8'h00, 1'b0, 1'b0, NO_PIN},
      '{8'h01, 1'b0, 1'b0, NO_PIN},
      '{8'h00, 1'b0, 1'b0, NO_PIN},
      '{DEPTH_24, 1'b0, 1'b0, NO_PIN},
      '{8'h00, 1'b0, 1'b0, NO_PIN},
      '{8'hAB, 1'b0, 1'b0, NO_PIN},
      '{8'h00, 1'b0, 1'b0, NO_PIN},
      '{8'h80, 1'b0, 1'b0, NO_PIN},
      '{8'hFF, 1'b0, 1'b1, WANT_ONE_PIXEL},
      '{8'h55, 1'b1, 1'b0, NO_PIN}
   };

   logic clock;
   logic reset;

   tgad_req_if req_bus ();
   tgad_rsp_if rsp_bus ();

   tga_truecolor_stream_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // decoder state as predicted
   decode_phase_type st_phase;
   logic [4:0]    st_hdr_count;
   logic [7:0]    st_id_left;
   logic          st_format_ok;
   logic [15:0]   st_width;
   logic [15:0]   st_height;
   logic          st_bgra;
   logic          st_top_down;
   logic [1:0]    st_pix_byte;
   logic [23:0]   st_pix_acc;
   logic [15:0]   st_col;
   logic [15:0]   st_row;

   result_type    due_results[$];
   logic [8:0]    file_bytes[$];
   bit            pin_on;
   result_type    pin_result;
   bit            hold_request;
   int            burst_left;
   bit            steady;
   int            useful_bytes;
   int            results_seen;
   int            mismatches;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void reset_decoder();
      st_phase     = ST_HEADER;
      st_hdr_count = '0;
      st_id_left   = '0;
      st_format_ok = 1'b0;
      st_width     = '0;
      st_height    = '0;
      st_bgra      = 1'b0;
      st_top_down  = 1'b0;
      st_pix_byte  = '0;
      st_pix_acc   = '0;
      st_col       = '0;
      st_row       = '0;
   endfunction

   function automatic result_type failure_result();
      result_type res;
      res              = '0;
      res.kind         = KIND_FAIL;
      res.image_width  = st_width;
      res.image_height = st_height;
      return res;
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic eof,
                                       output bit fires, output result_type res);
      logic [1:0]  last_idx;
      bit          final_px;
      bit          row_end;
      fires = 1'b0;
      res   = '0;
      case (st_phase)
         ST_HEADER: begin
            case (st_hdr_count)
               HDR_ID_LEN:    st_id_left = b;
               HDR_CMAP_TYPE: st_format_ok = (b == 8'd0);
               HDR_IMG_TYPE:  if (b != IMG_TYPE_TRUECOLOR) st_format_ok = 1'b0;
               HDR_WIDTH_LO:  st_width = {8'd0, b};
               HDR_WIDTH_HI:  st_width[15:8] = b;
               HDR_HEIGHT_LO: st_height = {8'd0, b};
               HDR_HEIGHT_HI: st_height[15:8] = b;
               HDR_DEPTH: begin
                  if (b == DEPTH_32) st_bgra = 1'b1;
                  else if (b == DEPTH_24) st_bgra = 1'b0;
                  else st_format_ok = 1'b0;
               end
               HDR_DESC:      st_top_down = b[DESC_TOP_DOWN_BIT];
               default: ;
            endcase
            st_hdr_count = st_hdr_count + 5'd1;
            if (st_hdr_count >= HEADER_BYTES) begin
               if (st_format_ok && st_width != 16'd0 && st_height != 16'd0) begin
                  st_phase = (st_id_left != 8'd0) ? ST_SKIP : ST_PIXELS;
               end else begin
                  fires    = 1'b1;
                  res      = failure_result();
                  st_phase = ST_FAILED;
               end
            end
         end
         ST_SKIP: begin
            st_id_left = st_id_left - 8'd1;
            if (st_id_left == 8'd0) st_phase = ST_PIXELS;
         end
         ST_PIXELS: begin
            last_idx = st_bgra ? 2'd3 : 2'd2;
            if (st_pix_byte < last_idx) begin
               st_pix_acc  = st_pix_acc | (24'(b) << (8 * st_pix_byte));
               st_pix_byte = st_pix_byte + 2'd1;
            end else begin
               row_end  = (32'(st_col) + 1 >= 32'(st_width));
               final_px = row_end && (32'(st_row) + 1 >= 32'(st_height));
               fires            = 1'b1;
               res.kind         = final_px ? KIND_LAST : KIND_PIXEL;
               res.blue         = st_pix_acc[7:0];
               res.green        = st_pix_acc[15:8];
               res.red          = st_bgra ? st_pix_acc[23:16] : b;
               res.alpha        = st_bgra ? b : ALPHA_OPAQUE;
               res.column       = st_col;
               res.dest_row     = st_top_down ? st_row : st_height - 16'd1 - st_row;
               res.image_width  = st_width;
               res.image_height = st_height;
               st_pix_byte = '0;
               st_pix_acc  = '0;
               if (final_px) begin
                  st_phase = ST_DONE;
               end else if (row_end) begin
                  st_col = '0;
                  st_row = st_row + 16'd1;
               end else begin
                  st_col = st_col + 16'd1;
               end
            end
         end
         default: ;
      endcase
      if (eof) begin
         if (st_phase == ST_HEADER || st_phase == ST_SKIP || st_phase == ST_PIXELS) begin
            fires = 1'b1;
            res   = failure_result();
         end
         reset_decoder();
      end
   endfunction

   function automatic void add_header(input logic [7:0] id_len, input logic [7:0] cmap,
                                      input logic [7:0] itype, input logic [15:0] w,
                                      input logic [15:0] h, input logic [7:0] depth,
                                      input logic [7:0] desc);
      file_bytes.push_back({1'b0, id_len});
      file_bytes.push_back({1'b0, cmap});
      file_bytes.push_back({1'b0, itype});
      repeat (9) file_bytes.push_back({1'b0, 8'($urandom)});
      file_bytes.push_back({1'b0, w[7:0]});
      file_bytes.push_back({1'b0, w[15:8]});
      file_bytes.push_back({1'b0, h[7:0]});
      file_bytes.push_back({1'b0, h[15:8]});
      file_bytes.push_back({1'b0, depth});
      file_bytes.push_back({1'b0, desc});
   endfunction

   function automatic void make_file(input bit big);
      int          pick;
      int          cut;
      logic [15:0] w;
      logic [15:0] h;
      logic [7:0]  id_len;
      logic [7:0]  depth;
      logic [7:0]  cmap;
      logic [7:0]  itype;
      bit          bgra;
      file_bytes.delete();
      pick  = big ? 0 : $urandom_range(0, 99);
      bgra  = 1'($urandom_range(0, 1));
      depth = bgra ? DEPTH_32 : DEPTH_24;
      if ($urandom_range(0, 19) == 0) id_len = 8'($urandom_range(200, 255));
      else if ($urandom_range(0, 1) == 0) id_len = 8'd0;
      else id_len = 8'($urandom_range(1, 4));
      if (big) id_len = 8'd0;
      if (pick < 60) begin
         // complete file, optional trailing bytes
         if (big) w = 16'd8;
         else if ($urandom_range(0, 19) == 0) w = 16'($urandom_range(16, 40));
         else w = 16'($urandom_range(1, 5));
         h = big ? 16'd4 : 16'($urandom_range(1, 4));
         add_header(id_len, 8'd0, IMG_TYPE_TRUECOLOR, w, h, depth, 8'($urandom));
         repeat (int'(id_len) + int'(w) * int'(h) * (bgra ? 4 : 3) + $urandom_range(0, 3))
            file_bytes.push_back({1'b0, 8'($urandom)});
      end else if (pick < 75) begin
         // good header, large or random size, cut short
         w = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535));
         h = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535));
         add_header(id_len, 8'd0, IMG_TYPE_TRUECOLOR, w, h, depth, 8'($urandom));
         repeat (int'(id_len) + $urandom_range(0, 40))
            file_bytes.push_back({1'b0, 8'($urandom)});
         cut = $urandom_range(1, file_bytes.size());
         while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end else if (pick < 90) begin
         // one header field out of range
         cmap  = 8'd0;
         itype = IMG_TYPE_TRUECOLOR;
         w     = 16'($urandom_range(1, 4));
         h     = 16'($urandom_range(1, 4));
         case ($urandom_range(0, 4))
            0: cmap = 8'($urandom_range(1, 255));
            1: begin
               itype = 8'($urandom);
               if (itype == IMG_TYPE_TRUECOLOR) itype = 8'd3;
            end
            2: begin
               depth = 8'($urandom);
               if (depth == DEPTH_24 || depth == DEPTH_32) depth = depth ^ 8'h01;
            end
            3: w = 16'd0;
            default: h = 16'd0;
         endcase
         add_header(id_len, cmap, itype, w, h, depth, 8'($urandom));
         repeat ($urandom_range(0, 4)) file_bytes.push_back({1'b0, 8'($urandom)});
      end else begin
         repeat ($urandom_range(1, 30)) file_bytes.push_back({1'b0, 8'($urandom)});
      end
      file_bytes[file_bytes.size() - 1][8] = 1'b1;
   endfunction

   task automatic idle_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
   endtask

   task automatic offer(input logic [7:0] d, input logic eof, input bit pin,
                        input result_type want);
      if (burst_left == 0) begin
         if (!steady && $urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 6));
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.data_byte   <= d;
      req_bus.end_of_file <= eof;
      pin_on     = pin;
      pin_result = want;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   task automatic report(input string what, input logic [15:0] got_v,
                         input logic [15:0] want_v);
      if (mismatches < MAX_REPORTS)
         $display("%0t: result %0d %s: got 0x%0h, want 0x%0h",
                  $time, results_seen, what, got_v, want_v);
      mismatches++;
   endtask

   always @(posedge clock) begin : scoreboard
      result_type want;
      bit         fires;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            if (st_phase != ST_DONE && st_phase != ST_FAILED) useful_bytes++;
            decode_byte(req_bus.data_byte, req_bus.end_of_file, fires, want);
            if (pin_on) due_results.push_back(pin_result);
            else if (fires) due_results.push_back(want);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (due_results.size() == 0) begin
               report("unexpected transfer, kind", 16'(rsp_bus.kind), 16'd0);
            end else begin
               want = due_results.pop_front();
               if (rsp_bus.kind !== want.kind)
                  report("kind", 16'(rsp_bus.kind), 16'(want.kind));
               if (rsp_bus.blue !== want.blue)
                  report("blue", 16'(rsp_bus.blue), 16'(want.blue));
               if (rsp_bus.green !== want.green)
                  report("green", 16'(rsp_bus.green), 16'(want.green));
               if (rsp_bus.red !== want.red)
                  report("red", 16'(rsp_bus.red), 16'(want.red));
               if (rsp_bus.alpha !== want.alpha)
                  report("alpha", 16'(rsp_bus.alpha), 16'(want.alpha));
               if (rsp_bus.column !== want.column)
                  report("column", rsp_bus.column, want.column);
               if (rsp_bus.dest_row !== want.dest_row)
                  report("dest_row", rsp_bus.dest_row, want.dest_row);
               if (rsp_bus.image_width !== want.image_width)
                  report("image_width", rsp_bus.image_width, want.image_width);
               if (rsp_bus.image_height !== want.image_height)
                  report("image_height", rsp_bus.image_height, want.image_height);
            end
         end
      end
   end

   // sink: changing stall patterns plus long hold-offs on request
   initial begin : receiver
      rx_mode_type mode;
      int       mode_left;
      int       hold_left;
      int       tick;
      mode      = RX_FREE;
      mode_left = 0;
      hold_left = 0;
      tick      = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         tick++;
         if (hold_request) begin
            hold_left    = $urandom_range(80, 160);
            hold_request = 1'b0;
         end
         if (mode_left == 0) begin
            mode      = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(50, 300);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (mode)
               RX_FREE:   rsp_bus.ready <= 1'b1;
               RX_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
               RX_MOSTLY: rsp_bus.ready <= ($urandom_range(0, 9) != 0);
               default:   rsp_bus.ready <= (tick % 3 == 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tga_truecolor_stream_decoder_tb: FAIL");
      $finish;
   end

   initial begin : stimulus
      int file_idx;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.data_byte   = 8'd0;
      req_bus.end_of_file = 1'b0;
      pin_on        = 1'b0;
      pin_result    = NO_PIN;
      hold_request  = 1'b0;
      burst_left    = 0;
      steady        = 1'b0;
      useful_bytes  = 0;
      results_seen  = 0;
      mismatches    = 0;
      file_idx      = 0;
      reset_decoder();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++)
         offer(DIR_TABLE[i].data, DIR_TABLE[i].eof, DIR_TABLE[i].pinned, DIR_TABLE[i].want);

      while (useful_bytes < DIR_ROWS + RANDOM_ITEMS) begin
         make_file(file_idx == 0);
         steady = ($urandom_range(0, 3) == 0);
         if (file_idx % 12 == 0) hold_request = 1'b1;
         foreach (file_bytes[k]) offer(file_bytes[k][7:0], file_bytes[k][8], 1'b0, NO_PIN);
         file_idx++;
      end
      idle_sender(1);

      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (due_results.size() != 0) report("results missing", 16'(due_results.size()), 16'd0);
      if (mismatches == 0) begin
         $display("tga_truecolor_stream_decoder_tb: PASS");
      end else begin
         $display("tga_truecolor_stream_decoder_tb: FAIL");
      end
      $finish;
   end

endmodule

// File: files.f
design/tgad_pkg.sv
design/tgad_if.sv
design/tgad_core.sv
design/tgad_out.sv
design/tga_truecolor_stream_decoder.sv
design/tgad_chk.sv
verif/tga_truecolor_stream_decoder_tb.sv
